FILE: hw/rtl/amdfw_pkg.sv
// Shared widths, defaults and action codes for the adjacency matrix walk block.
package amdfw_pkg;

    // Fixed request and response field widths
    localparam int ACTION_W = 2;
    localparam int VTX_W    = 3;

    // Default graph size
    localparam int VERTEX_COUNT_DEF = 8;

    // Request action codes; code 3 is unused and dropped
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD  = 2'd0,
        ACT_TEST = 2'd1,
        ACT_WALK = 2'd2
    } t_action;

endpackage

FILE: hw/rtl/amdfw_adj_ram.sv
// Adjacency row memory with per-row valid bits so reset reads back as all zero.
module amdfw_adj_ram
    import amdfw_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
    parameter int AW           = $clog2(VERTEX_COUNT)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [VERTEX_COUNT-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic [VERTEX_COUNT-1:0] o_rdata
);

    logic [VERTEX_COUNT-1:0] r_mem [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] r_row_valid;
    logic [VERTEX_COUNT-1:0] r_rd_data;
    logic                    r_rd_valid;

    // Track which rows were ever written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_row_valid[i_raddr];
            end
        end
    end

    // Write and registered read of the row array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    // Mask rows never written
    assign o_rdata = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: hw/rtl/amdfw_vtx_ram.sv
// Simple dual-port vertex memory with a registered read, used for the stack and visit order.
module amdfw_vtx_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write and hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

FILE: hw/rtl/adjacency_matrix_depth_first_walk_top.sv
// Top level: request sequencer around the adjacency, stack and visit order memories.
//
//  channel   | direction | handshake          | payload
//  request   | in        | i_valid / o_ready  | i_action, i_source_vertex, i_target_vertex
//  response  | out       | o_valid / i_ready  | o_vertex, o_connected, o_found, o_last
//
// One request at a time. Add edge does two read-modify-writes of the adjacency
// memory, test edge one row read. A walk pushes the source, reads the row of each
// popped vertex that is not the target, pushes its unvisited neighbors, and on the target
// pop emits the visit order; a miss, same or out-of-range vertices give one response.
// Reset clears the adjacency rows through valid bits at once; no sweep is needed.
// A stalled response holds the sequencer only when a new response must be loaded.
module adjacency_matrix_depth_first_walk_top
    import amdfw_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [VTX_W-1:0]    i_source_vertex,
    input  logic [VTX_W-1:0]    i_target_vertex,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [VTX_W-1:0]    o_vertex,
    output logic                o_connected,
    output logic                o_found,
    output logic                o_last
);

    localparam int VW = $clog2(VERTEX_COUNT);
    localparam int CW = $clog2(VERTEX_COUNT + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD_U,
        S_ADD_WR_U,
        S_ADD_RD_V,
        S_ADD_WR_V,
        S_TEST_RD,
        S_TEST_OUT,
        S_WALK_INIT,
        S_NOTFOUND,
        S_SAME,
        S_POP,
        S_POP_WAIT,
        S_SCAN_LOAD,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [VW-1:0]           r_src, n_src;
    logic [VW-1:0]           r_dst, n_dst;
    logic                    r_in_range, n_in_range;
    logic                    r_same, n_same;
    logic [CW-1:0]           r_level, n_level;
    logic [CW-1:0]           r_count, n_count;
    logic [VW-1:0]           r_k, n_k;
    logic [VERTEX_COUNT-1:0] r_visited, n_visited;
    logic [VERTEX_COUNT-1:0] r_row, n_row;
    logic                    r_out_valid, n_out_valid;
    logic [VTX_W-1:0]        r_vertex, n_vertex;
    logic                    r_connected, n_connected;
    logic                    r_found, n_found;
    logic                    r_last, n_last;

    // Memory ports
    logic                    adj_we, adj_re;
    logic [VW-1:0]           adj_waddr, adj_raddr;
    logic [VERTEX_COUNT-1:0] adj_wdata, adj_rdata;
    logic                    stk_we, stk_re;
    logic [VW-1:0]           stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic                    ord_we, ord_re;
    logic [VW-1:0]           ord_waddr, ord_raddr, ord_wdata, ord_rdata;

    logic                    in_accept;
    logic                    out_free;
    logic [VERTEX_COUNT-1:0] low_bit;
    logic [VW-1:0]           low_idx;
    logic [CW-1:0]           level_dec;
    logic                    emit_last;

    assign in_accept = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign level_dec = r_level - CW'(1);
    assign emit_last = (CW'(r_k) + CW'(1)) == r_count;

    // Isolate the lowest pending neighbor and encode its index
    assign low_bit = r_row & (~r_row + VERTEX_COUNT'(1));
    always_comb begin
        low_idx = '0;
        for (int b = 0; b < VW; b++) begin
            for (int i = 0; i < VERTEX_COUNT; i++) begin
                if (((i >> b) & 1) == 1) begin
                    low_idx[b] = low_idx[b] | low_bit[i];
                end
            end
        end
    end

    // Sequence requests and drive memory ports
    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_dst       = r_dst;
        n_in_range  = r_in_range;
        n_same      = r_same;
        n_level     = r_level;
        n_count     = r_count;
        n_k         = r_k;
        n_visited   = r_visited;
        n_row       = r_row;
        n_out_valid = r_out_valid && !i_ready;
        n_vertex    = r_vertex;
        n_connected = r_connected;
        n_found     = r_found;
        n_last      = r_last;

        adj_we    = 1'b0;
        adj_re    = 1'b0;
        adj_waddr = r_src;
        adj_raddr = r_src;
        adj_wdata = adj_rdata;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = r_level[VW-1:0];
        stk_raddr = level_dec[VW-1:0];
        stk_wdata = low_idx;
        ord_we    = 1'b0;
        ord_re    = 1'b0;
        ord_waddr = r_count[VW-1:0];
        ord_raddr = r_k;
        ord_wdata = stk_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_src      = VW'(i_source_vertex);
                    n_dst      = VW'(i_target_vertex);
                    n_in_range = (32'(i_source_vertex) < VERTEX_COUNT)
                              && (32'(i_target_vertex) < VERTEX_COUNT);
                    n_same     = i_source_vertex == i_target_vertex;
                    unique case (i_action)
                        ACT_ADD:  n_state = n_in_range ? S_ADD_RD_U : S_IDLE;
                        ACT_TEST: n_state = S_TEST_RD;
                        ACT_WALK: n_state = S_WALK_INIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD_U: begin
                adj_re  = 1'b1;
                n_state = S_ADD_WR_U;
            end
            S_ADD_WR_U: begin
                adj_we    = 1'b1;
                adj_wdata = adj_rdata | (VERTEX_COUNT'(1) << r_dst);
                n_state   = S_ADD_RD_V;
            end
            S_ADD_RD_V: begin
                adj_re    = 1'b1;
                adj_raddr = r_dst;
                n_state   = S_ADD_WR_V;
            end
            S_ADD_WR_V: begin
                adj_we    = 1'b1;
                adj_waddr = r_dst;
                adj_wdata = adj_rdata | (VERTEX_COUNT'(1) << r_src);
                n_state   = S_IDLE;
            end
            S_TEST_RD: begin
                adj_re  = 1'b1;
                n_state = S_TEST_OUT;
            end
            S_TEST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_vertex    = '0;
                    n_connected = r_in_range && adj_rdata[r_dst];
                    n_found     = 1'b0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_WALK_INIT: begin
                if (!r_in_range) begin
                    n_state = S_NOTFOUND;
                end else if (r_same) begin
                    n_state = S_SAME;
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = r_src;
                    n_level   = CW'(1);
                    n_count   = '0;
                    n_visited = '0;
                    n_state   = S_POP;
                end
            end
            S_NOTFOUND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_vertex    = '0;
                    n_connected = 1'b0;
                    n_found     = 1'b0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SAME: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_vertex    = VTX_W'(r_src);
                    n_connected = 1'b0;
                    n_found     = 1'b1;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_POP: begin
                if (r_level == '0) begin
                    n_state = S_NOTFOUND;
                end else begin
                    stk_re  = 1'b1;
                    n_level = level_dec;
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                // Record the popped vertex and mark it visited
                ord_we    = 1'b1;
                n_count   = r_count + CW'(1);
                n_visited = r_visited | (VERTEX_COUNT'(1) << stk_rdata);
                if (stk_rdata == r_dst) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    adj_re    = 1'b1;
                    adj_raddr = stk_rdata;
                    n_state   = S_SCAN_LOAD;
                end
            end
            S_SCAN_LOAD: begin
                // Every unvisited neighbor gets pushed, so mark them all now
                n_row     = adj_rdata & ~r_visited;
                n_visited = r_visited | adj_rdata;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (r_row == '0) begin
                    n_state = S_POP;
                end else begin
                    stk_we  = 1'b1;
                    n_level = r_level + CW'(1);
                    n_row   = r_row & ~low_bit;
                end
            end
            S_EMIT_RD: begin
                ord_re  = 1'b1;
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_vertex    = VTX_W'(ord_rdata);
                    n_connected = 1'b0;
                    n_found     = 1'b1;
                    n_last      = emit_last;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + VW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_count     <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_count     <= n_count;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
        end
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_in_range  <= n_in_range;
        r_same      <= n_same;
        r_k         <= n_k;
        r_row       <= n_row;
        r_vertex    <= n_vertex;
        r_connected <= n_connected;
        r_found     <= n_found;
        r_last      <= n_last;
    end

    assign o_ready     = r_state == S_IDLE;
    assign o_valid     = r_out_valid;
    assign o_vertex    = r_vertex;
    assign o_connected = r_connected;
    assign o_found     = r_found;
    assign o_last      = r_last;

    amdfw_adj_ram #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .AW           (VW)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    amdfw_vtx_ram #(
        .DEPTH (VERTEX_COUNT),
        .AW    (VW),
        .DW    (VW)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    amdfw_vtx_ram #(
        .DEPTH (VERTEX_COUNT),
        .AW    (VW),
        .DW    (VW)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_re    (ord_re),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // Stack never holds more vertices than the graph has
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_level) <= VERTEX_COUNT)
        else $error("stack level overflow");

    // Visit order never grows past the vertex count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= VERTEX_COUNT)
        else $error("visit count overflow");

    // A failed walk or edge test always ends its request in one response
    a_notfound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last)
        else $error("response without found must be last");

    // An edge test answer never claims a walk result
    a_conn_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_connected |-> o_last && !o_found)
        else $error("connected response mixed with walk response");

    // A walk request keeps the request side closed on the next cycle
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_action == ACT_WALK) |=> !o_ready)
        else $error("request taken while walk in progress");

endmodule

FILE: bench/tb_adjacency_matrix_depth_first_walk_top.sv
// Testbench for the adjacency matrix depth-first walk block: directed and random requests.
`timescale 1ns / 100ps

module tb_adjacency_matrix_depth_first_walk_top;
    import amdfw_pkg::*;

    // Action code 3 has no package name; the block drops it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int NODES = VERTEX_COUNT_DEF;
    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             connected;
        logic             found;
        logic             last;
    } t_walk_response;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [ACTION_W-1:0] i_action = '0;
    logic [VTX_W-1:0]    i_source_vertex = '0;
    logic [VTX_W-1:0]    i_target_vertex = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [VTX_W-1:0]    o_vertex;
    logic                o_connected;
    logic                o_found;
    logic                o_last;

    // Expected graph contents and the responses still owed by the block
    logic [NODES-1:0] graph_rows [NODES];
    t_walk_response   expected_fifo [EXP_DEPTH];
    int               exp_rd = 0;
    int               exp_wr = 0;
    int               exp_fill = 0;
    int               error_count = 0;
    bit               steady_flow = 1'b0;
    int               req_gap = 0;
    int               resp_hold = 0;

    adjacency_matrix_depth_first_walk_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_source_vertex (i_source_vertex),
        .i_target_vertex (i_target_vertex),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_vertex        (o_vertex),
        .o_connected     (o_connected),
        .o_found         (o_found),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("[adjacency_matrix_depth_first_walk_top] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // Draw an idle count for one request or one response
    function automatic int idle_draw();
        return steady_flow ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Append one expected response to the tail of the expectation buffer
    function automatic void add_expected(input logic [VTX_W-1:0] vtx,
                                         input logic             conn,
                                         input logic             fnd,
                                         input logic             lst);
        expected_fifo[exp_wr] = {vtx, conn, fnd, lst};
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_fill++;
    endfunction

    // Apply one request to the graph copy and queue the responses it owes
    function automatic void predict_graph_request(input logic [ACTION_W-1:0] act,
                                                  input logic [VTX_W-1:0] src,
                                                  input logic [VTX_W-1:0] dst);
        logic [NODES-1:0] seen;
        logic [VTX_W-1:0] stack [NODES];
        logic [VTX_W-1:0] order [NODES];
        logic [VTX_W-1:0] cur;
        int               depth;
        int               hits;
        bit               reached;
        case (act)
            ACT_ADD: begin
                graph_rows[src][dst] = 1'b1;
                graph_rows[dst][src] = 1'b1;
            end
            ACT_TEST: begin
                add_expected('0, graph_rows[src][dst], 1'b0, 1'b1);
            end
            ACT_WALK: begin
                if (src == dst) begin
                    add_expected(src, 1'b0, 1'b1, 1'b1);
                end else begin
                    seen = '0;
                    stack[0] = src;
                    depth = 1;
                    hits = 0;
                    reached = 1'b0;
                    // Pop, record, then push unvisited neighbors lowest index first
                    while (depth > 0 && !reached) begin
                        depth--;
                        cur = stack[depth];
                        if (hits < NODES) begin
                            order[hits] = cur;
                            hits++;
                        end
                        seen[cur] = 1'b1;
                        if (cur == dst) begin
                            reached = 1'b1;
                        end else begin
                            for (int n = 0; n < NODES; n++) begin
                                if (graph_rows[cur][n] && !seen[n]) begin
                                    seen[n] = 1'b1;
                                    if (depth < NODES) begin
                                        stack[depth] = VTX_W'(n);
                                        depth++;
                                    end
                                end
                            end
                        end
                    end
                    if (reached) begin
                        for (int k = 0; k < hits; k++) begin
                            add_expected(order[k], 1'b0, 1'b1, (k == hits - 1));
                        end
                    end else begin
                        add_expected('0, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Drive one request, hold it until accepted, then predict its responses
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [VTX_W-1:0] src,
                                input logic [VTX_W-1:0] dst);
        repeat (req_gap) @(posedge i_clk);
        i_valid         <= 1'b1;
        i_action        <= act;
        i_source_vertex <= src;
        i_target_vertex <= dst;
        do @(posedge i_clk); while (!o_ready);
        predict_graph_request(act, src, dst);
        // Keep valid up only when the next request follows at once
        req_gap = idle_draw();
        if (req_gap != 0) i_valid <= 1'b0;
    endtask

    // Compare one accepted response with the oldest expectation
    task automatic check_response();
        t_walk_response want;
        if (exp_fill == 0) begin
            report_mismatch($sformatf(
                "response with none pending: vertex %0d conn %0b found %0b last %0b",
                o_vertex, o_connected, o_found, o_last));
            return;
        end
        want = expected_fifo[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_DEPTH;
        exp_fill--;
        if (o_vertex !== want.vertex)
            report_mismatch($sformatf("vertex got %0d want %0d", o_vertex, want.vertex));
        if (o_connected !== want.connected)
            report_mismatch($sformatf("connected got %0b want %0b",
                                      o_connected, want.connected));
        if (o_found !== want.found)
            report_mismatch($sformatf("found got %0b want %0b", o_found, want.found));
        if (o_last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", o_last, want.last));
    endtask

    // Accept responses and stall the response side at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            check_response();
            resp_hold = idle_draw();
            if (resp_hold != 0) i_ready <= 1'b0;
        end else if (!i_ready) begin
            if (resp_hold <= 1) i_ready <= 1'b1;
            else resp_hold--;
        end
    end

    // Empty graph: no edges, every walk to another vertex fails
    task automatic test_empty_graph();
        send_request(ACT_TEST, 3'd0, 3'd7);
        send_request(ACT_TEST, 3'd7, 3'd7);
        send_request(ACT_WALK, 3'd0, 3'd7);
        send_request(ACT_WALK, 3'd7, 3'd7);
        send_request(ACT_WALK, 3'd5, 3'd2);
    endtask

    // Edge updates: symmetric entries, self loop, dropped action code
    task automatic test_edge_updates();
        send_request(ACT_ADD, 3'd0, 3'd1);
        send_request(ACT_ADD, 3'd7, 3'd1);
        send_request(ACT_ADD, 3'd3, 3'd3);
        send_request(ACT_TEST, 3'd1, 3'd0);
        send_request(ACT_TEST, 3'd1, 3'd7);
        send_request(ACT_TEST, 3'd3, 3'd3);
        send_request(ACT_TEST, 3'd0, 3'd7);
        send_request(ACT_UNUSED, 3'd5, 3'd2);
        send_request(ACT_TEST, 3'd5, 3'd2);
    endtask

    // Directed walks: chain, branching order, self loop and unreachable target
    task automatic test_directed_walks();
        send_request(ACT_WALK, 3'd0, 3'd7);
        send_request(ACT_ADD, 3'd0, 3'd2);
        send_request(ACT_ADD, 3'd2, 3'd6);
        send_request(ACT_ADD, 3'd4, 3'd0);
        send_request(ACT_WALK, 3'd0, 3'd6);
        send_request(ACT_WALK, 3'd6, 3'd7);
        send_request(ACT_WALK, 3'd3, 3'd5);
        send_request(ACT_ADD, 3'd5, 3'd6);
        send_request(ACT_WALK, 3'd7, 3'd5);
    endtask

    // Random traffic in segments, some with no idling on either side
    task automatic test_random_traffic();
        int pick;
        int counted;
        logic [ACTION_W-1:0] act;
        for (int seg = 0; seg < 8; seg++) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            counted = 0;
            while (counted < 18) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) act = ACT_ADD;
                else if (pick < 40) act = ACT_TEST;
                else if (pick < 95) act = ACT_WALK;
                else act = ACT_UNUSED;
                send_request(act, VTX_W'($urandom_range(0, NODES - 1)),
                             VTX_W'($urandom_range(0, NODES - 1)));
                if (act != ACT_UNUSED) counted++;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        for (int r = 0; r < NODES; r++) graph_rows[r] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_graph();
        test_edge_updates();
        test_directed_walks();
        test_random_traffic();

        // Drop valid after the last request, drain, then let the block settle
        if (req_gap == 0) i_valid <= 1'b0;
        while (exp_fill != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (error_count == 0)
            $display("[adjacency_matrix_depth_first_walk_top] OK");
        else
            $display("[adjacency_matrix_depth_first_walk_top] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/amdfw_pkg.sv
hw/rtl/amdfw_adj_ram.sv
hw/rtl/amdfw_vtx_ram.sv
hw/rtl/adjacency_matrix_depth_first_walk_top.sv
bench/tb_adjacency_matrix_depth_first_walk_top.sv
